// ===== hdl/iopd_pkg.sv =====
// Shared types and decode constants for the I/O port decoder.
// Holds the target codes, the mask/match patterns and the request/result records.
// No dependencies.
package iopd_pkg;

	typedef enum logic [3:0] {
		TGT_NONE       = 4'd0,
		TGT_AY_SEL     = 4'd1,
		TGT_AY_DATA    = 4'd2,
		TGT_SERIAL     = 4'd3,
		TGT_RTC_ADDR   = 4'd4,
		TGT_RTC_DATA   = 4'd5,
		TGT_BOARD      = 4'd6,
		TGT_ULA        = 4'd7,
		TGT_PAGING     = 4'd8,
		TGT_EXT_PAGING = 4'd9,
		TGT_ROM_WINDOW = 4'd10,
		TGT_FDC        = 4'd11,
		TGT_BORDER     = 4'd12,
		TGT_PERIPH     = 4'd13
	} tgt_t;

	// configuration register indexes
	localparam logic CFG_EXT_MODEL = 1'b0;
	localparam logic CFG_BOARD     = 1'b1;

	// access kinds
	localparam logic FUNC_READ = 1'b0;

	// mask/match patterns
	localparam logic [15:0] MASK_TURBO      = 16'hC023;
	localparam logic [15:0] MATCH_TURBO_ON  = 16'h4021;
	localparam logic [15:0] MATCH_TURBO_OFF = 16'h0021;
	localparam logic [15:0] MASK_AY         = 16'hC002;
	localparam logic [15:0] MATCH_AY_SEL    = 16'hC000;
	localparam logic [15:0] MATCH_AY_DATA   = 16'h8000;
	localparam logic [15:0] MASK_BOARD      = 16'h18FB;
	localparam logic [15:0] MATCH_BOARD     = 16'h18BA;
	localparam logic [15:0] MASK_ULA        = 16'h0023;
	localparam logic [15:0] MATCH_ULA       = 16'h0022;
	localparam logic [15:0] MASK_PAGE       = 16'hD027;
	localparam logic [15:0] MATCH_PAGE      = 16'h5025;
	localparam logic [15:0] MATCH_EXT_PAGE  = 16'h1025;
	localparam logic [15:0] MASK_ROMWIN     = 16'hD127;
	localparam logic [15:0] MATCH_ROMWIN    = 16'h5025;

	// board sub-device selects, address masked by MASK_BSUB
	localparam logic [15:0] MASK_BSUB    = 16'hA044;
	localparam logic [15:0] BSUB_SERIAL  = 16'hA000;
	localparam logic [15:0] BSUB_CLOCK   = 16'h8000;
	localparam logic [15:0] BSUB_FDD     = 16'h2000;
	localparam logic [15:0] BSUB_STATUS  = 16'h0000;
	localparam logic [15:0] BSUB_ID_LO   = 16'h0004;
	localparam logic [15:0] BSUB_ID_HI   = 16'h2004;
	localparam logic [15:0] BSUB_ZERO    = 16'h8004;
	localparam logic [15:0] BSUB_TASK    = 16'hA004;

	// canonical forward ports
	localparam logic [15:0] FP_AY_SEL     = 16'hFFFD;
	localparam logic [15:0] FP_AY_DATA    = 16'hBFFD;
	localparam logic [15:0] FP_ULA        = 16'h00FE;
	localparam logic [15:0] FP_PAGING     = 16'h7FFD;
	localparam logic [15:0] FP_EXT_PAGING = 16'h1FFD;
	localparam logic [15:0] FP_ROM_WINDOW = 16'h7EFD;
	localparam logic [15:0] FP_BORDER     = 16'h00FF;

	// fixed read bytes
	localparam logic [7:0] RD_FLOAT_ONE = 8'hFF;
	localparam logic [7:0] RD_SER_LOW   = 8'hBF;
	localparam logic [7:0] RD_STATUS    = 8'h3F;
	localparam logic [7:0] RD_ID        = 8'h57;
	localparam logic [7:0] RD_TASK_TOP  = 8'h50;
	localparam logic [5:0] FDD_LOW_ONES = 6'h3F;

	localparam logic [2:0] TF_FIRST = 3'd0;
	localparam logic [2:0] TF_LAST  = 3'd7;

	typedef struct packed {
		logic        func;
		logic [15:0] port_address;
		logic [7:0]  write_data;
		logic        dos_session;
		logic        dos_trigger;
		logic [7:0]  ext_read_data;
		logic        ext_responded;
		logic [7:0]  floating_attr;
	} req_t;

	typedef struct packed {
		tgt_t        target;
		logic [15:0] forward_port;
		logic [7:0]  read_data;
		logic        decoded;
		logic        fdc_gated;
		logic        turbo_on;
		logic [7:0]  paging_value;
		logic [7:0]  ext_paging_value;
		logic [7:0]  rom_window_value;
		logic [2:0]  border_value;
	} res_t;

endpackage

// ===== hdl/io_port_decoder_with_paging_latches.sv =====
// I/O port decoder with paging latches: top level, single-pass decode.
// A request is taken into the input register, then decoded into the result register
// and presented from there. Throughput: one request per cycle while the output is taken.
// The decode and every latch update sit between the input register and the result register.
// Reset (arst_n low) clears both pipeline valids, the config bits and all latches.
// Depends on iopd_pkg.
module io_port_decoder_with_paging_latches (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [15:0]          port_address,
	input  logic [7:0]           write_data,
	input  logic                 dos_session,
	input  logic                 dos_trigger,
	input  logic [7:0]           ext_read_data,
	input  logic                 ext_responded,
	input  logic [7:0]           floating_attr,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           target,
	output logic [15:0]          forward_port,
	output logic [7:0]           read_data,
	output logic                 decoded,
	output logic                 fdc_gated,
	output logic                 turbo_on,
	output logic [7:0]           paging_value,
	output logic [7:0]           ext_paging_value,
	output logic [7:0]           rom_window_value,
	output logic [2:0]           border_value,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic                 cfg_data
);
	import iopd_pkg::*;

	// pipeline
	req_t req_s1;
	logic valid_s1;
	res_t res_q;
	logic out_valid_q;
	logic adv;

	// configuration
	logic ext_model_q;
	logic board_present_q;

	// architectural latches
	logic [7:0] paging_q, ext_paging_q, rom_window_q;
	logic       lock_q, turbo_q;
	logic [2:0] border_q;
	logic       board_sys_b7_q;   // only bit 7 of the board system latch is ever observed
	logic [1:0] board_fdd_q;      // reads OR in 3F, so only the top two bits survive
	logic [7:0] task_q [8];

	// next-state values
	logic [7:0] paging_d, ext_paging_d, rom_window_d;
	logic       lock_d, turbo_d, board_sys_b7_d;
	logic [2:0] border_d;
	logic [1:0] board_fdd_d;
	logic       tf_we;
	logic [2:0] tf_idx;
	res_t       res_d;

	// decode helpers
	logic [15:0] p;
	logic [7:0]  lo;
	logic        disk, disk_on;

	// Handshake: the input register advances whenever the result register is empty or
	// being drained, so a new request is taken in the same cycle a result leaves.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= '{func: func, port_address: port_address, write_data: write_data,
				dos_session: dos_session, dos_trigger: dos_trigger,
				ext_read_data: ext_read_data, ext_responded: ext_responded,
				floating_attr: floating_attr};
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	// Configuration bits; an index outside the list does nothing since the index is one bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_model_q     <= 1'b0;
			board_present_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXT_MODEL: ext_model_q     <= cfg_data;
				CFG_BOARD:     board_present_q <= cfg_data;
				default:       ext_model_q     <= ext_model_q;
			endcase
		end
	end

	// Latch state: commit the decoded request's updates when it moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q       <= '0;
			lock_q         <= 1'b0;
			ext_paging_q   <= '0;
			rom_window_q   <= '0;
			turbo_q        <= 1'b0;
			border_q       <= '0;
			board_sys_b7_q <= 1'b0;
			board_fdd_q    <= '0;
			for (int i = 0; i < 8; i++) begin
				task_q[i] <= '0;
			end
		end else if (adv) begin
			paging_q       <= paging_d;
			lock_q         <= lock_d;
			ext_paging_q   <= ext_paging_d;
			rom_window_q   <= rom_window_d;
			turbo_q        <= turbo_d;
			border_q       <= border_d;
			board_sys_b7_q <= board_sys_b7_d;
			board_fdd_q    <= board_fdd_d;
			if (tf_we) begin
				task_q[tf_idx] <= req_s1.write_data;
			end
		end
	end

	// Decode: one priority chain for reads, another for writes.
	always_comb begin
		p       = req_s1.port_address;
		lo      = p[7:0];
		disk    = (lo == 8'h1F) || (lo == 8'h3F) || (lo == 8'h5F) || (lo == 8'h7F)
			|| (lo == 8'hFF);
		// disk controller is on the bus with an open session, the monitor bit or the trigger
		disk_on = req_s1.dos_session || ext_paging_q[1] || req_s1.dos_trigger;
		tf_idx  = p[10:8];
		tf_we   = 1'b0;

		paging_d       = paging_q;
		lock_d         = lock_q;
		ext_paging_d   = ext_paging_q;
		rom_window_d   = rom_window_q;
		turbo_d        = turbo_q;
		border_d       = border_q;
		board_sys_b7_d = board_sys_b7_q;
		board_fdd_d    = board_fdd_q;

		res_d = '0;
		res_d.target = TGT_NONE;

		if (req_s1.func == FUNC_READ) begin
			// turbo strobe fires on any matching read, whoever answers it
			if ((p & MASK_TURBO) == MATCH_TURBO_ON) begin
				turbo_d = 1'b1;
			end else if ((p & MASK_TURBO) == MATCH_TURBO_OFF) begin
				turbo_d = 1'b0;
			end

			if ((p & MASK_AY) == MATCH_AY_SEL) begin
				res_d.target       = TGT_AY_SEL;
				res_d.forward_port = FP_AY_SEL;
				res_d.decoded      = req_s1.ext_responded;
				res_d.read_data    = req_s1.ext_read_data;
			end else if ((p & MASK_AY) == MATCH_AY_DATA) begin
				res_d.target       = TGT_AY_DATA;
				res_d.forward_port = FP_AY_DATA;
				res_d.decoded      = req_s1.ext_responded;
				res_d.read_data    = req_s1.ext_read_data;
			end else if (ext_model_q && ((p & MASK_BOARD) == MATCH_BOARD)) begin
				res_d.target       = TGT_BOARD;
				res_d.forward_port = p;
				res_d.decoded      = 1'b1;
				res_d.read_data    = RD_FLOAT_ONE;
				if (board_present_q) begin
					case (p & MASK_BSUB)
						BSUB_SERIAL: begin
							res_d.target    = TGT_SERIAL;
							res_d.read_data = req_s1.ext_read_data[6] ? RD_FLOAT_ONE
								: RD_SER_LOW;
						end
						BSUB_CLOCK: begin
							res_d.target    = TGT_RTC_DATA;
							res_d.read_data = req_s1.ext_read_data;
						end
						BSUB_FDD:    res_d.read_data = {board_fdd_q, FDD_LOW_ONES};
						BSUB_STATUS: res_d.read_data = RD_STATUS;
						BSUB_ID_LO,
						BSUB_ID_HI:  res_d.read_data = RD_ID;
						BSUB_ZERO:   res_d.read_data = 8'h00;
						BSUB_TASK: begin
							if (tf_idx == TF_FIRST) begin
								res_d.read_data = 8'h00;
							end else if (tf_idx == TF_LAST) begin
								res_d.read_data = RD_TASK_TOP;
							end else begin
								res_d.read_data = task_q[tf_idx];
							end
						end
						default:     res_d.read_data = RD_FLOAT_ONE;
					endcase
				end
			end else if ((p & MASK_ULA) == MATCH_ULA) begin
				res_d.target       = TGT_ULA;
				res_d.forward_port = FP_ULA;
				res_d.decoded      = 1'b1;
				res_d.read_data    = req_s1.ext_read_data;
			end else if ((p & MASK_PAGE) == MATCH_EXT_PAGE) begin
				res_d.target       = TGT_EXT_PAGING;
				res_d.forward_port = FP_EXT_PAGING;
				res_d.decoded      = 1'b1;
				res_d.read_data    = RD_FLOAT_ONE;
			end else if (ext_model_q && ((p & MASK_ROMWIN) == MATCH_ROMWIN)) begin
				res_d.target       = TGT_ROM_WINDOW;
				res_d.forward_port = FP_ROM_WINDOW;
				res_d.decoded      = 1'b1;
				res_d.read_data    = RD_FLOAT_ONE;
			end else if (disk && !disk_on) begin
				res_d.fdc_gated = 1'b1;
			end else begin
				res_d.target       = disk ? TGT_FDC : TGT_PERIPH;
				res_d.forward_port = disk ? {8'h00, lo} : p;
				res_d.decoded      = req_s1.ext_responded;
				res_d.read_data    = req_s1.ext_read_data;
			end
			// nobody claimed the read: float the screen attribute
			if (!res_d.decoded) begin
				res_d.read_data = req_s1.floating_attr;
			end
		end else begin
			res_d.decoded = 1'b1;
			if (ext_model_q && ((p & MASK_ROMWIN) == MATCH_ROMWIN)) begin
				rom_window_d       = req_s1.write_data;
				res_d.target       = TGT_ROM_WINDOW;
				res_d.forward_port = FP_ROM_WINDOW;
			end else if ((p & MASK_PAGE) == MATCH_PAGE) begin
				// a write with bit 5 set is stored and then freezes the latch until reset
				if (!lock_q) begin
					paging_d = req_s1.write_data;
					lock_d   = req_s1.write_data[5];
				end
				res_d.target       = TGT_PAGING;
				res_d.forward_port = FP_PAGING;
			end else if ((p & MASK_PAGE) == MATCH_EXT_PAGE) begin
				ext_paging_d       = req_s1.write_data;
				res_d.target       = TGT_EXT_PAGING;
				res_d.forward_port = FP_EXT_PAGING;
			end else if (ext_model_q && ((p & MASK_BOARD) == MATCH_BOARD)) begin
				res_d.target       = TGT_BOARD;
				res_d.forward_port = p;
				if (board_present_q) begin
					case (p & MASK_BSUB)
						BSUB_SERIAL: begin
							board_sys_b7_d = req_s1.write_data[7];
							res_d.target   = TGT_SERIAL;
						end
						BSUB_CLOCK:  res_d.target = board_sys_b7_q ? TGT_RTC_DATA
							: TGT_RTC_ADDR;
						BSUB_FDD:    board_fdd_d = req_s1.write_data[7:6];
						BSUB_TASK:   tf_we = 1'b1;
						default:     res_d.target = TGT_BOARD;
					endcase
				end
			end else if ((p & MASK_ULA) == MATCH_ULA) begin
				border_d           = req_s1.write_data[2:0];
				res_d.target       = TGT_ULA;
				res_d.forward_port = FP_ULA;
			end else if ((p & MASK_AY) == MATCH_AY_SEL) begin
				// the sound chip keeps its own copy of the select latch
				res_d.target       = TGT_AY_SEL;
				res_d.forward_port = FP_AY_SEL;
			end else if ((p & MASK_AY) == MATCH_AY_DATA) begin
				res_d.target       = TGT_AY_DATA;
				res_d.forward_port = FP_AY_DATA;
			end else if (disk && disk_on) begin
				res_d.target       = TGT_FDC;
				res_d.forward_port = {8'h00, lo};
			end else if (lo == 8'hFF) begin
				// gated controller: low byte FF lands on the border instead
				border_d           = req_s1.write_data[2:0];
				res_d.target       = TGT_BORDER;
				res_d.forward_port = FP_BORDER;
				res_d.fdc_gated    = 1'b1;
			end else if (disk) begin
				res_d.decoded   = 1'b0;
				res_d.fdc_gated = 1'b1;
			end else begin
				res_d.target       = TGT_PERIPH;
				res_d.forward_port = p;
			end
		end

		res_d.turbo_on         = turbo_d;
		res_d.paging_value     = paging_d;
		res_d.ext_paging_value = ext_paging_d;
		res_d.rom_window_value = rom_window_d;
		res_d.border_value     = border_d;
	end

	assign target           = res_q.target;
	assign forward_port     = res_q.forward_port;
	assign read_data        = res_q.read_data;
	assign decoded          = res_q.decoded;
	assign fdc_gated        = res_q.fdc_gated;
	assign turbo_on         = res_q.turbo_on;
	assign paging_value     = res_q.paging_value;
	assign ext_paging_value = res_q.ext_paging_value;
	assign rom_window_value = res_q.rom_window_value;
	assign border_value     = res_q.border_value;

	// the paging lock never drops once set
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |=> lock_q)
		else $error("paging lock cleared without reset");

	// a locked primary latch holds its value
	a_lock_holds: assert property (@(posedge clk) disable iff (!arst_n)
		lock_q |=> $stable(paging_q))
		else $error("locked paging latch changed");

	// a gated disk access lands nowhere or on the border
	a_gated_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.fdc_gated) |->
		(res_q.target == TGT_NONE || res_q.target == TGT_BORDER))
		else $error("gated disk access routed to a device");

	// no target means no forward port and no claim
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.target == TGT_NONE) |->
		(res_q.forward_port == 16'h0000 && !res_q.decoded))
		else $error("unrouted access carries a port or a claim");

	// the input side only stalls behind a held request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

endmodule
